// ----- hdl/kbsc_pkg.sv -----
// Types, codes and key maps for the scan code to ASCII ring block.
// Stand-alone package; kbsc_decode and the top level import it.
package kbsc_pkg;

    // Operation carried with each input beat.
    typedef enum logic [1:0] {
        OP_SCAN  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_RESET = 2'd3
    } kbsc_op_t;

    // Set-1 scan code fields and special keys.
    localparam int          SC_BREAK_BIT = 7;
    localparam logic [6:0]  SC_LSHIFT    = 7'h2A;
    localparam logic [6:0]  SC_RSHIFT    = 7'h36;
    localparam logic [6:0]  SC_CTRL      = 7'h1D;
    localparam logic [6:0]  SC_ALT       = 7'h38;
    localparam logic [6:0]  MAP_LEN      = 7'd64;

    // Result of decoding one scan code against the modifier state.
    typedef struct packed {
        logic       shift_next;
        logic       ctrl_next;
        logic       push_req;
        logic [6:0] push_char;
    } kbsc_scan_t;

    function automatic logic [6:0] map_plain(input logic [5:0] code);
        logic [6:0] ch;
        ch = 7'h00;
        case (code)
            6'd1:  ch = 7'h1B;
            6'd2:  ch = 7'h31;
            6'd3:  ch = 7'h32;
            6'd4:  ch = 7'h33;
            6'd5:  ch = 7'h34;
            6'd6:  ch = 7'h35;
            6'd7:  ch = 7'h36;
            6'd8:  ch = 7'h37;
            6'd9:  ch = 7'h38;
            6'd10: ch = 7'h39;
            6'd11: ch = 7'h30;
            6'd12: ch = 7'h2D;
            6'd13: ch = 7'h3D;
            6'd14: ch = 7'h08;
            6'd15: ch = 7'h09;
            6'd16: ch = 7'h71;
            6'd17: ch = 7'h77;
            6'd18: ch = 7'h65;
            6'd19: ch = 7'h72;
            6'd20: ch = 7'h74;
            6'd21: ch = 7'h79;
            6'd22: ch = 7'h75;
            6'd23: ch = 7'h69;
            6'd24: ch = 7'h6F;
            6'd25: ch = 7'h70;
            6'd26: ch = 7'h5B;
            6'd27: ch = 7'h5D;
            6'd28: ch = 7'h0A;
            6'd30: ch = 7'h61;
            6'd31: ch = 7'h73;
            6'd32: ch = 7'h64;
            6'd33: ch = 7'h66;
            6'd34: ch = 7'h67;
            6'd35: ch = 7'h68;
            6'd36: ch = 7'h6A;
            6'd37: ch = 7'h6B;
            6'd38: ch = 7'h6C;
            6'd39: ch = 7'h3B;
            6'd40: ch = 7'h27;
            6'd41: ch = 7'h60;
            6'd43: ch = 7'h5C;
            6'd44: ch = 7'h7A;
            6'd45: ch = 7'h78;
            6'd46: ch = 7'h63;
            6'd47: ch = 7'h76;
            6'd48: ch = 7'h62;
            6'd49: ch = 7'h6E;
            6'd50: ch = 7'h6D;
            6'd51: ch = 7'h2C;
            6'd52: ch = 7'h2E;
            6'd53: ch = 7'h2F;
            6'd57: ch = 7'h20;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [6:0] map_shift(input logic [5:0] code);
        logic [6:0] ch;
        ch = 7'h00;
        case (code)
            6'd1:  ch = 7'h1B;
            6'd2:  ch = 7'h21;
            6'd3:  ch = 7'h40;
            6'd4:  ch = 7'h23;
            6'd5:  ch = 7'h24;
            6'd6:  ch = 7'h25;
            6'd7:  ch = 7'h5E;
            6'd8:  ch = 7'h26;
            6'd9:  ch = 7'h2A;
            6'd10: ch = 7'h28;
            6'd11: ch = 7'h29;
            6'd12: ch = 7'h5F;
            6'd13: ch = 7'h2B;
            6'd14: ch = 7'h08;
            6'd15: ch = 7'h09;
            6'd16: ch = 7'h51;
            6'd17: ch = 7'h57;
            6'd18: ch = 7'h45;
            6'd19: ch = 7'h52;
            6'd20: ch = 7'h54;
            6'd21: ch = 7'h59;
            6'd22: ch = 7'h55;
            6'd23: ch = 7'h49;
            6'd24: ch = 7'h4F;
            6'd25: ch = 7'h50;
            6'd26: ch = 7'h7B;
            6'd27: ch = 7'h7D;
            6'd28: ch = 7'h0A;
            6'd30: ch = 7'h41;
            6'd31: ch = 7'h53;
            6'd32: ch = 7'h44;
            6'd33: ch = 7'h46;
            6'd34: ch = 7'h47;
            6'd35: ch = 7'h48;
            6'd36: ch = 7'h4A;
            6'd37: ch = 7'h4B;
            6'd38: ch = 7'h4C;
            6'd39: ch = 7'h3A;
            6'd40: ch = 7'h22;
            6'd41: ch = 7'h7E;
            6'd43: ch = 7'h7C;
            6'd44: ch = 7'h5A;
            6'd45: ch = 7'h58;
            6'd46: ch = 7'h43;
            6'd47: ch = 7'h56;
            6'd48: ch = 7'h42;
            6'd49: ch = 7'h4E;
            6'd50: ch = 7'h4D;
            6'd51: ch = 7'h3C;
            6'd52: ch = 7'h3E;
            6'd53: ch = 7'h3F;
            6'd57: ch = 7'h20;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [6:0] map_ctrl(input logic [5:0] code);
        logic [6:0] ch;
        ch = 7'h00;
        case (code)
            6'd1:  ch = 7'h1B;
            6'd16: ch = 7'h11;
            6'd17: ch = 7'h17;
            6'd18: ch = 7'h05;
            6'd19: ch = 7'h12;
            6'd20: ch = 7'h14;
            6'd21: ch = 7'h19;
            6'd22: ch = 7'h15;
            6'd23: ch = 7'h09;
            6'd24: ch = 7'h0F;
            6'd25: ch = 7'h10;
            6'd28: ch = 7'h0A;
            6'd30: ch = 7'h01;
            6'd31: ch = 7'h13;
            6'd32: ch = 7'h04;
            6'd33: ch = 7'h06;
            6'd34: ch = 7'h07;
            6'd35: ch = 7'h08;
            6'd36: ch = 7'h0A;
            6'd37: ch = 7'h0B;
            6'd38: ch = 7'h0C;
            6'd44: ch = 7'h1A;
            6'd45: ch = 7'h18;
            6'd46: ch = 7'h03;
            6'd47: ch = 7'h16;
            6'd48: ch = 7'h02;
            6'd49: ch = 7'h0E;
            6'd50: ch = 7'h0D;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

endpackage

// ----- hdl/kbsc_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependencies.
module kbsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/kbsc_decode.sv -----
// Scan code decoder: modifier tracking and key map lookup for one set-1 code.
// Depends on kbsc_pkg for the key maps and special codes.
module kbsc_decode (
    input  logic                scan_byte,
    input  logic [7:0]          scan_code,
    input  logic                shift_held,
    input  logic                ctrl_held,
    output kbsc_pkg::kbsc_scan_t res
);
    import kbsc_pkg::*;

    logic [6:0] code;
    logic       is_break;
    logic       is_shift;
    logic       is_ctrl;
    logic [6:0] ch;

    assign code     = scan_code[6:0];
    assign is_break = scan_code[SC_BREAK_BIT];
    assign is_shift = (code == SC_LSHIFT) || (code == SC_RSHIFT);
    assign is_ctrl  = (code == SC_CTRL);

    // Shift wins over ctrl when both are held.
    always_comb begin
        if (shift_held) begin
            ch = map_shift(code[5:0]);
        end else if (ctrl_held) begin
            ch = map_ctrl(code[5:0]);
        end else begin
            ch = map_plain(code[5:0]);
        end
    end

    always_comb begin
        res.shift_next = shift_held;
        res.ctrl_next  = ctrl_held;
        res.push_req   = 1'b0;
        res.push_char  = ch;
        if (scan_byte) begin
            if (is_shift) begin
                res.shift_next = !is_break;
            end else if (is_ctrl) begin
                res.ctrl_next = !is_break;
            end else if (!is_break && code != SC_ALT && code < MAP_LEN) begin
                res.push_req = (ch != 7'h00);
            end
        end
    end

endmodule

// ----- hdl/keyboard_scancode_to_ascii_fifo_core.sv -----
// Top level of the set-1 scan code to ASCII converter with a character ring.
// Depends on kbsc_pkg, kbsc_decode and kbsc_ram.
//
//  Channel | Direction | Payload
//  --------+-----------+------------------------------------------------------
//  s_      | in        | tuser: opcode[1:0]; tdata: scan_byte[7:0]
//  m_      | out       | tuser: read_valid; tdata: read_char[6:0],
//          |           |        fill_count[14:7], has_data[15]
//
// One result beat per input beat, one beat per cycle sustained while m_tready stays high. An input beat
// lands in an input register; in the cycle it moves on, the decoder, the ring
// pointers and the single RAM access (a write for a push, a read for a pop)
// all act at once, and at the next edge the result beat is in the output
// register, where m_tvalid rises with it.
// The RAM read port is registered, and its data feeds read_char, forced to zero on a beat that is no pop.
// Reset (aresetn low, synchronous) empties the ring and drops both modifiers;
// the ring contents are not cleared and need no clearing pass.
// When m_tready is low the output register holds, the input register fills,
// and s_tready then drops until the result beat is taken.
module keyboard_scancode_to_ascii_fifo_core #(
    parameter int DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] scan_byte
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [6:0] read_char, [14:7] fill_count, [15] has_data
    output logic        m_tuser    // [0] read_valid
);
    import kbsc_pkg::*;

    localparam int PTR_W      = $clog2(DEPTH);
    localparam int FILL_EXT_W = PTR_W + 8;

    // Input register stage.
    logic       a_valid_reg;
    kbsc_op_t   a_op_reg;
    logic [7:0] a_scan_reg;

    // Ring and modifier state.
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [PTR_W-1:0] cnt_reg, cnt_next;
    logic             shift_reg, shift_next;
    logic             ctrl_reg, ctrl_next;

    // Output register stage.
    logic       b_valid_reg;
    logic       b_pop_reg, b_pop_next;
    logic [7:0] b_fill_reg, b_fill_next;
    logic       b_has_reg, b_has_next;

    logic                  b_free;
    logic                  a_adv;
    logic                  s_acc;
    logic                  ring_full;
    logic                  ram_we;
    logic                  ram_re;
    logic [6:0]            ram_rdata;
    logic [FILL_EXT_W-1:0] cnt_ext;
    kbsc_scan_t            scan_res;

    assign b_free   = !b_valid_reg || m_tready;
    assign a_adv    = a_valid_reg && b_free;
    assign s_tready = !a_valid_reg || b_free;
    assign s_acc    = s_tvalid && s_tready;

    assign ring_full = (cnt_reg == PTR_W'(DEPTH - 1));

    kbsc_decode u_decode (
        .scan_byte (a_op_reg == OP_SCAN),
        .scan_code (a_scan_reg),
        .shift_held(shift_reg),
        .ctrl_held (ctrl_reg),
        .res       (scan_res)
    );

    // State update for the beat leaving the input register.
    always_comb begin
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        ctrl_next  = ctrl_reg;
        b_pop_next = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        if (a_adv) begin
            unique case (a_op_reg)
                OP_SCAN: begin
                    shift_next = scan_res.shift_next;
                    ctrl_next  = scan_res.ctrl_next;
                    if (scan_res.push_req && !ring_full) begin
                        ram_we   = 1'b1;
                        wp_next  = (wp_reg == PTR_W'(DEPTH - 1)) ? '0 : wp_reg + PTR_W'(1);
                        cnt_next = cnt_reg + PTR_W'(1);
                    end
                end
                OP_POP: begin
                    if (cnt_reg != '0) begin
                        ram_re     = 1'b1;
                        b_pop_next = 1'b1;
                        rp_next    = (rp_reg == PTR_W'(DEPTH - 1)) ? '0 : rp_reg + PTR_W'(1);
                        cnt_next   = cnt_reg - PTR_W'(1);
                    end
                end
                OP_CLEAR: begin
                    wp_next  = '0;
                    rp_next  = '0;
                    cnt_next = '0;
                end
                OP_RESET: begin
                    wp_next    = '0;
                    rp_next    = '0;
                    cnt_next   = '0;
                    shift_next = 1'b0;
                    ctrl_next  = 1'b0;
                end
                default: begin
                    wp_next = wp_reg;
                end
            endcase
        end
    end

    // The fill count on the port saturates at 255 for deep rings.
    assign cnt_ext     = FILL_EXT_W'(cnt_next);
    assign b_fill_next = (cnt_ext > FILL_EXT_W'(255)) ? 8'hFF : cnt_ext[7:0];
    assign b_has_next  = (cnt_next != '0);

    kbsc_ram #(
        .WIDTH(7),
        .DEPTH(DEPTH)
    ) u_ring (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(wp_reg),
        .wr_data(scan_res.push_char),
        .rd_en  (ram_re),
        .rd_addr(rp_reg),
        .rd_data(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            wp_reg      <= '0;
            rp_reg      <= '0;
            cnt_reg     <= '0;
            shift_reg   <= 1'b0;
            ctrl_reg    <= 1'b0;
        end else begin
            if (s_tready) begin
                a_valid_reg <= s_tvalid;
            end
            if (b_free) begin
                b_valid_reg <= a_valid_reg;
            end
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            cnt_reg   <= cnt_next;
            shift_reg <= shift_next;
            ctrl_reg  <= ctrl_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            a_op_reg   <= kbsc_op_t'(s_tuser);
            a_scan_reg <= s_tdata;
        end
        if (a_adv) begin
            b_pop_reg  <= b_pop_next;
            b_fill_reg <= b_fill_next;
            b_has_reg  <= b_has_next;
        end
    end

    // The RAM read register only moves on a pop, which can only happen once
    // the previous result beat has left, so it holds during a stall.
    assign m_tvalid = b_valid_reg;
    assign m_tuser  = b_pop_reg;
    assign m_tdata  = {b_has_reg, b_fill_reg, (b_pop_reg ? ram_rdata : 7'h00)};

    // Checks: pointer and count consistency, count bounds, pop bookkeeping, has_data against fill_count.
    logic [PTR_W:0] rp_plus_cnt;
    logic [PTR_W:0] wp_expect;

    assign rp_plus_cnt = {1'b0, rp_reg} + {1'b0, cnt_reg};
    assign wp_expect   = (rp_plus_cnt >= (PTR_W + 1)'(DEPTH))
                       ? rp_plus_cnt - (PTR_W + 1)'(DEPTH) : rp_plus_cnt;

    a_ptr_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, wp_reg} == wp_expect)
        else $error("write pointer does not match read pointer plus count");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, cnt_reg} <= (PTR_W + 1)'(DEPTH - 1))
        else $error("ring count exceeds capacity");

    a_pop_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_adv && a_op_reg == OP_POP && cnt_reg != '0)
        |=> (cnt_reg == $past(cnt_reg) - PTR_W'(1)) && b_pop_reg)
        else $error("successful pop did not consume one entry");

    a_has_matches_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15] == (m_tdata[14:7] != 8'h00)))
        else $error("has_data disagrees with fill_count");

endmodule
